// ===== rtl/oaht_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// oaht_pkg
// Shared constants, command and status codes and types for the hash table.
// ----------------------------------------------------------------------------
package oaht_pkg;

    localparam int DEF_TABLE_SLOTS = 1024;
    localparam int DEF_KEY_BITS    = 64;

    localparam logic [9:0] LOAD_LIMIT_RESET = 10'd682;

    // command codes
    localparam logic [2:0] CMD_INSERT  = 3'd0;
    localparam logic [2:0] CMD_LOOKUP  = 3'd1;
    localparam logic [2:0] CMD_REMOVE  = 3'd2;
    localparam logic [2:0] CMD_CLEAR   = 3'd3;
    localparam logic [2:0] CMD_ITERATE = 3'd4;

    // status codes
    localparam logic [1:0] ST_DONE = 2'd0;
    localparam logic [1:0] ST_MISS = 2'd1;
    localparam logic [1:0] ST_DUP  = 2'd2;
    localparam logic [1:0] ST_FULL = 2'd3;

    // slot marks
    localparam logic [1:0] MARK_EMPTY = 2'd0;
    localparam logic [1:0] MARK_LIVE  = 2'd1;
    localparam logic [1:0] MARK_TOMB  = 2'd2;

    // write request into the slot store
    typedef struct packed {
        logic       mark_we;
        logic       kd_we;
        logic [1:0] mark;
    } t_slot_wr;

endpackage

// ===== rtl/oaht_slot_store.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// oaht_slot_store
// Mark, key and data memories: one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module oaht_slot_store #(
    parameter int TABLE_SLOTS = oaht_pkg::DEF_TABLE_SLOTS,
    parameter int KEY_BITS    = oaht_pkg::DEF_KEY_BITS,
    parameter int IW          = $clog2(TABLE_SLOTS)
) (
    input  logic                  i_clk,
    input  logic [IW-1:0]         i_rd_addr,
    input  logic [IW-1:0]         i_wr_addr,
    input  oaht_pkg::t_slot_wr    i_wr,
    input  logic [KEY_BITS-1:0]   i_wr_key,
    input  logic [63:0]           i_wr_data,
    output logic [1:0]            o_mark,
    output logic [KEY_BITS-1:0]   o_key,
    output logic [63:0]           o_data
);
    import oaht_pkg::*;

    logic [1:0]          mark_mem [TABLE_SLOTS];
    logic [KEY_BITS-1:0] key_mem  [TABLE_SLOTS];
    logic [63:0]         data_mem [TABLE_SLOTS];

    logic [1:0]          r_mark;
    logic [KEY_BITS-1:0] r_key;
    logic [63:0]         r_data;

    // mark memory
    always_ff @(posedge i_clk) begin
        if (i_wr.mark_we) begin
            mark_mem[i_wr_addr] <= i_wr.mark;
        end
        r_mark <= mark_mem[i_rd_addr];
    end

    // key and data memories
    always_ff @(posedge i_clk) begin
        if (i_wr.kd_we) begin
            key_mem[i_wr_addr]  <= i_wr_key;
            data_mem[i_wr_addr] <= i_wr_data;
        end
        r_key  <= key_mem[i_rd_addr];
        r_data <= data_mem[i_rd_addr];
    end

    assign o_mark = r_mark;
    assign o_key  = r_key;
    assign o_data = r_data;

endmodule

// ===== rtl/open_address_hash_table_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// open_address_hash_table_unit
// Open-addressed key/data table with perturbed probing, held in block memory.
// ----------------------------------------------------------------------------
// A command is taken when start is high and busy is low; its result word is on
// the outputs for one cycle with o_result_strobe and must be captured then.
// Insert, lookup and remove probe slots with one memory read per probe, and
// the result word is registered from the last probe. Iterate scans one slot
// per cycle from start_index. Clear sweeps the mark memory, one slot a cycle.
// After reset the same sweep runs with busy high; the load limit may be
// written meanwhile. Invalid commands return at once with status not found.
module open_address_hash_table_unit #(
    parameter int TABLE_SLOTS = oaht_pkg::DEF_TABLE_SLOTS,
    parameter int KEY_BITS    = oaht_pkg::DEF_KEY_BITS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        i_cfg_wr_en,
    input  logic [9:0]  i_cfg_wr_data,
    input  logic [2:0]  i_cmd,
    input  logic [63:0] i_key_value,
    input  logic [63:0] i_hash_value,
    input  logic [63:0] i_data_value,
    input  logic [10:0] i_start_index,
    output logic        o_result_strobe,
    output logic [1:0]  o_status,
    output logic [63:0] o_found_data,
    output logic [63:0] o_found_key,
    output logic [10:0] o_next_index,
    output logic [9:0]  o_live_entries
);
    import oaht_pkg::*;

    localparam int IW = $clog2(TABLE_SLOTS);
    localparam logic [IW:0]   GUARD_LAST = (IW+1)'(TABLE_SLOTS + 16 - 1);
    localparam logic [IW-1:0] LAST_SLOT  = IW'(TABLE_SLOTS - 1);
    localparam logic [16:0]   MAX_LIMIT  = 17'(TABLE_SLOTS - 1);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_PROBE = 2'd1;
    localparam logic [1:0] S_ITER  = 2'd2;
    localparam logic [1:0] S_SWEEP = 2'd3;

    logic [1:0]          r_state, n_state;
    logic [IW-1:0]       r_idx, n_idx;
    logic [63:0]         r_perturb, n_perturb;
    logic [IW:0]         r_steps, n_steps;
    logic [2:0]          r_cmd, n_cmd;
    logic [KEY_BITS-1:0] r_key, n_key;
    logic [63:0]         r_data, n_data;
    logic [IW:0]         r_occ, n_occ;
    logic [IW:0]         r_live, n_live;
    logic [9:0]          r_limit, n_limit;
    logic                r_clr, n_clr;
    logic                r_strobe, n_strobe;
    logic [1:0]          r_status, n_status;
    logic [63:0]         r_fdata, n_fdata;
    logic [63:0]         r_fkey, n_fkey;
    logic [10:0]         r_nidx, n_nidx;

    t_slot_wr            slot_wr;
    logic [IW-1:0]       wr_addr;
    logic [1:0]          q_mark;
    logic [KEY_BITS-1:0] q_key;
    logic [63:0]         q_data;

    logic [63:0]         adv_pert;
    logic [IW-1:0]       adv_idx;
    logic                key_eq;
    logic [16:0]         lim_eff;
    logic                is_full;

    oaht_slot_store #(
        .TABLE_SLOTS (TABLE_SLOTS),
        .KEY_BITS    (KEY_BITS),
        .IW          (IW)
    ) u_store (
        .i_clk     (i_clk),
        .i_rd_addr (n_idx),
        .i_wr_addr (wr_addr),
        .i_wr      (slot_wr),
        .i_wr_key  (r_key),
        .i_wr_data (r_data),
        .o_mark    (q_mark),
        .o_key     (q_key),
        .o_data    (q_data)
    );

    // next probe slot: slot*5 + perturb + 1, perturb shifted first
    assign adv_pert = r_perturb >> 5;
    assign adv_idx  = {r_idx[IW-3:0], 2'b00} + r_idx + adv_pert[IW-1:0] + IW'(1);
    assign key_eq   = (q_key == r_key);

    // effective load limit keeps one slot empty
    assign lim_eff = (17'(r_limit) > MAX_LIMIT) ? MAX_LIMIT : 17'(r_limit);
    assign is_full = (17'(r_occ) >= lim_eff);

    always_comb begin
        n_state   = r_state;
        n_idx     = r_idx;
        n_perturb = r_perturb;
        n_steps   = r_steps;
        n_cmd     = r_cmd;
        n_key     = r_key;
        n_data    = r_data;
        n_occ     = r_occ;
        n_live    = r_live;
        n_limit   = i_cfg_wr_en ? i_cfg_wr_data : r_limit;
        n_clr     = r_clr;
        n_strobe  = 1'b0;
        n_status  = r_status;
        n_fdata   = r_fdata;
        n_fkey    = r_fkey;
        n_nidx    = r_nidx;
        slot_wr   = '0;
        wr_addr   = r_idx;

        case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_cmd     = i_cmd;
                    n_key     = i_key_value[KEY_BITS-1:0];
                    n_data    = i_data_value;
                    n_perturb = i_hash_value;
                    n_steps   = '0;
                    n_fdata   = '0;
                    n_fkey    = '0;
                    n_nidx    = '0;
                    n_status  = ST_MISS;
                    case (i_cmd)
                        CMD_INSERT, CMD_LOOKUP, CMD_REMOVE: begin
                            n_idx   = i_hash_value[IW-1:0];
                            n_state = S_PROBE;
                        end
                        CMD_CLEAR: begin
                            n_idx   = '0;
                            n_occ   = '0;
                            n_live  = '0;
                            n_clr   = 1'b1;
                            n_state = S_SWEEP;
                        end
                        CMD_ITERATE: begin
                            if (32'(i_start_index) >= 32'(TABLE_SLOTS)) begin
                                n_nidx   = 11'(TABLE_SLOTS);
                                n_strobe = 1'b1;
                            end else begin
                                n_idx   = i_start_index[IW-1:0];
                                n_state = S_ITER;
                            end
                        end
                        default: begin
                            n_strobe = 1'b1;
                        end
                    endcase
                end
            end

            S_PROBE: begin
                n_nidx = 11'(r_idx);
                if (q_mark == MARK_EMPTY) begin
                    // miss; insert fills this slot unless the table is full
                    n_state  = S_IDLE;
                    n_strobe = 1'b1;
                    if (r_cmd == CMD_INSERT) begin
                        if (is_full) begin
                            n_status = ST_FULL;
                        end else begin
                            n_status      = ST_DONE;
                            slot_wr.mark_we = 1'b1;
                            slot_wr.kd_we   = 1'b1;
                            slot_wr.mark    = MARK_LIVE;
                            n_occ  = r_occ + 1'b1;
                            n_live = r_live + 1'b1;
                        end
                    end
                end else if (q_mark == MARK_LIVE && key_eq) begin
                    n_state  = S_IDLE;
                    n_strobe = 1'b1;
                    n_fdata  = q_data;
                    if (r_cmd == CMD_INSERT) begin
                        n_status = ST_DUP;
                    end else begin
                        n_status = ST_DONE;
                        if (r_cmd == CMD_REMOVE) begin
                            slot_wr.mark_we = 1'b1;
                            slot_wr.mark    = MARK_TOMB;
                            if (r_live != '0) begin
                                n_live = r_live - 1'b1;
                            end
                        end
                    end
                end else begin
                    // advance the probe; give up at the step guard
                    n_perturb = adv_pert;
                    n_idx     = adv_idx;
                    n_steps   = r_steps + 1'b1;
                    if (r_steps == GUARD_LAST) begin
                        n_state  = S_IDLE;
                        n_strobe = 1'b1;
                        n_nidx   = 11'(adv_idx);
                        n_status = (r_cmd == CMD_INSERT) ? ST_FULL : ST_MISS;
                    end
                end
            end

            S_ITER: begin
                if (q_mark == MARK_LIVE) begin
                    n_state  = S_IDLE;
                    n_strobe = 1'b1;
                    n_status = ST_DONE;
                    n_fkey   = 64'(q_key);
                    n_fdata  = q_data;
                    n_nidx   = 11'({1'b0, r_idx} + 1'b1);
                end else if (r_idx == LAST_SLOT) begin
                    n_state  = S_IDLE;
                    n_strobe = 1'b1;
                    n_nidx   = 11'(TABLE_SLOTS);
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end

            S_SWEEP: begin
                // mark every slot empty, one a cycle
                slot_wr.mark_we = 1'b1;
                slot_wr.mark    = MARK_EMPTY;
                if (r_idx == LAST_SLOT) begin
                    n_state  = S_IDLE;
                    n_clr    = 1'b0;
                    n_strobe = r_clr;
                    n_status = ST_DONE;
                    n_idx    = '0;
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_SWEEP;
            r_idx    <= '0;
            r_occ    <= '0;
            r_live   <= '0;
            r_limit  <= LOAD_LIMIT_RESET;
            r_clr    <= 1'b0;
            r_strobe <= 1'b0;
            r_steps  <= '0;
        end else begin
            r_state  <= n_state;
            r_idx    <= n_idx;
            r_occ    <= n_occ;
            r_live   <= n_live;
            r_limit  <= n_limit;
            r_clr    <= n_clr;
            r_strobe <= n_strobe;
            r_steps  <= n_steps;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_perturb <= n_perturb;
        r_cmd     <= n_cmd;
        r_key     <= n_key;
        r_data    <= n_data;
        r_status  <= n_status;
        r_fdata   <= n_fdata;
        r_fkey    <= n_fkey;
        r_nidx    <= n_nidx;
    end

    assign busy            = (r_state != S_IDLE);
    assign o_result_strobe = r_strobe;
    assign o_status        = r_status;
    assign o_found_data    = r_fdata;
    assign o_found_key     = r_fkey;
    assign o_next_index    = r_nidx;
    assign o_live_entries  = 10'(r_live);

endmodule

// ===== rtl/oaht_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// oaht_checker
// Port-level checks on the command and result words of the hash table.
// ----------------------------------------------------------------------------
module oaht_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        start,
    input logic        busy,
    input logic        o_result_strobe,
    input logic [1:0]  o_status,
    input logic [63:0] o_found_data,
    input logic [63:0] o_found_key
);
    import oaht_pkg::*;

    // an accepted command is either at work or answered next cycle
    a_accept_moves: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> busy || o_result_strobe)
        else $error("accepted command neither busy nor answered");

    // a result word is shown only once the unit is free again
    a_strobe_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_strobe |-> !busy)
        else $error("result strobe while busy");

    // full carries no entry
    a_full_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_strobe && o_status == ST_FULL |-> o_found_data == 64'd0)
        else $error("full status with data");

    // only a successful iterate returns a key
    a_key_only_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_strobe && o_status != ST_DONE |-> o_found_key == 64'd0)
        else $error("key returned with failing status");

endmodule

bind open_address_hash_table_unit oaht_checker u_oaht_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .start           (start),
    .busy            (busy),
    .o_result_strobe (o_result_strobe),
    .o_status        (o_status),
    .o_found_data    (o_found_data),
    .o_found_key     (o_found_key)
);

// ===== verif/open_address_hash_table_unit_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// open_address_hash_table_unit_test
// Self-checking bench for the hash table unit. A behavioural table predicts
// every result word; commands are driven with random idle gaps and the load
// limit is changed between phases while the unit is idle.
// ----------------------------------------------------------------------------
module open_address_hash_table_unit_test;
    import oaht_pkg::*;

    localparam int SLOTS = 1024;
    localparam int CYCLE_LIMIT = 4000000;

    // result word as predicted
    typedef struct {
        logic [1:0]  status;
        logic [63:0] fdata;
        logic [63:0] fkey;
        logic [10:0] nidx;
        logic [9:0]  live;
    } t_word;

    // ------------------------------------------------------------------------
    // Scoreboard: shadow table plus queue of expected words
    // ------------------------------------------------------------------------
    class hash_table_board;
        logic [1:0]  mark [SLOTS];
        logic [63:0] skey [SLOTS];
        logic [63:0] sdata [SLOTS];
        int unsigned occupied;
        int unsigned live;
        int unsigned limit;
        t_word       pending [$];
        int          errors;

        function new();
            foreach (mark[i]) mark[i] = MARK_EMPTY;
            occupied = 0;
            live = 0;
            limit = 32'(LOAD_LIMIT_RESET);
            errors = 0;
        endfunction

        // walk the perturbed probe sequence
        function bit probe(logic [63:0] key, logic [63:0] hash, output int where);
            logic [63:0] idx;
            logic [63:0] pert;
            idx = hash & (SLOTS - 1);
            pert = hash;
            for (int s = 0; s < SLOTS + 16; s++) begin
                if (mark[idx] == MARK_EMPTY) begin
                    where = int'(idx);
                    return 0;
                end
                if (mark[idx] == MARK_LIVE && skey[idx] == key) begin
                    where = int'(idx);
                    return 1;
                end
                pert = pert >> 5;
                idx = (idx * 5 + pert + 1) & (SLOTS - 1);
            end
            where = int'(idx);
            return 0;
        endfunction

        function void note_command(logic [2:0] cmd, logic [63:0] key, logic [63:0] hash,
                                   logic [63:0] data, logic [10:0] sidx);
            t_word w;
            int where;
            int lim;
            bit hit;
            w.status = ST_MISS;
            w.fdata = '0;
            w.fkey = '0;
            w.nidx = '0;
            where = 0;
            case (cmd)
                CMD_INSERT: begin
                    hit = probe(key, hash, where);
                    w.nidx = 11'(where);
                    lim = (limit > SLOTS - 1) ? SLOTS - 1 : limit;
                    if (hit) begin
                        w.status = ST_DUP;
                        w.fdata = sdata[where];
                    end else if (occupied >= lim || mark[where] != MARK_EMPTY) begin
                        w.status = ST_FULL;
                    end else begin
                        mark[where] = MARK_LIVE;
                        skey[where] = key;
                        sdata[where] = data;
                        occupied++;
                        live++;
                        w.status = ST_DONE;
                    end
                end
                CMD_LOOKUP: begin
                    hit = probe(key, hash, where);
                    w.nidx = 11'(where);
                    if (hit) begin
                        w.status = ST_DONE;
                        w.fdata = sdata[where];
                    end
                end
                CMD_REMOVE: begin
                    hit = probe(key, hash, where);
                    w.nidx = 11'(where);
                    if (hit) begin
                        w.status = ST_DONE;
                        w.fdata = sdata[where];
                        mark[where] = MARK_TOMB;
                        if (live > 0) live--;
                    end
                end
                CMD_CLEAR: begin
                    foreach (mark[i]) mark[i] = MARK_EMPTY;
                    occupied = 0;
                    live = 0;
                    w.status = ST_DONE;
                end
                CMD_ITERATE: begin
                    w.nidx = 11'(SLOTS);
                    for (int i = sidx; i < SLOTS; i++) begin
                        if (mark[i] == MARK_LIVE) begin
                            w.status = ST_DONE;
                            w.fkey = skey[i];
                            w.fdata = sdata[i];
                            w.nidx = 11'(i + 1);
                            break;
                        end
                    end
                end
                default: ;
            endcase
            w.live = live[9:0];
            pending.push_back(w);
        endfunction

        function void check_word(t_word got);
            t_word exp;
            if (pending.size() == 0) begin
                $display("%0t: unexpected result word, status %0d", $realtime, got.status);
                errors++;
                return;
            end
            exp = pending.pop_front();
            if (got.status !== exp.status) begin
                $display("%0t: status exp %0d got %0d", $realtime, exp.status, got.status);
                errors++;
            end
            if (got.fdata !== exp.fdata) begin
                $display("%0t: found_data exp %h got %h", $realtime, exp.fdata, got.fdata);
                errors++;
            end
            if (got.fkey !== exp.fkey) begin
                $display("%0t: found_key exp %h got %h", $realtime, exp.fkey, got.fkey);
                errors++;
            end
            if (got.nidx !== exp.nidx) begin
                $display("%0t: next_index exp %0d got %0d", $realtime, exp.nidx, got.nidx);
                errors++;
            end
            if (got.live !== exp.live) begin
                $display("%0t: live_entries exp %0d got %0d", $realtime, exp.live, got.live);
                errors++;
            end
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    logic        i_cfg_wr_en;
    logic [9:0]  i_cfg_wr_data;
    logic [2:0]  i_cmd;
    logic [63:0] i_key_value;
    logic [63:0] i_hash_value;
    logic [63:0] i_data_value;
    logic [10:0] i_start_index;
    logic        o_result_strobe;
    logic [1:0]  o_status;
    logic [63:0] o_found_data;
    logic [63:0] o_found_key;
    logic [10:0] o_next_index;
    logic [9:0]  o_live_entries;

    hash_table_board board;
    int unsigned cycle_count;
    int unsigned idle_pct;
    logic [63:0] key_pool [16];
    logic [63:0] hash_pool [16];

    open_address_hash_table_unit dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_cfg_wr_en     (i_cfg_wr_en),
        .i_cfg_wr_data   (i_cfg_wr_data),
        .i_cmd           (i_cmd),
        .i_key_value     (i_key_value),
        .i_hash_value    (i_hash_value),
        .i_data_value    (i_data_value),
        .i_start_index   (i_start_index),
        .o_result_strobe (o_result_strobe),
        .o_status        (o_status),
        .o_found_data    (o_found_data),
        .o_found_key     (o_found_key),
        .o_next_index    (o_next_index),
        .o_live_entries  (o_live_entries)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // capture result words and watch the cycle budget
    always @(posedge i_clk) begin
        t_word got;
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("open_address_hash_table_unit regression: fail");
            $finish;
        end
        if (i_rst_n && o_result_strobe) begin
            got.status = o_status;
            got.fdata = o_found_data;
            got.fkey = o_found_key;
            got.nidx = o_next_index;
            got.live = o_live_entries;
            board.check_word(got);
        end
    end

    // issue one command word; hold start until the unit takes it.
    // start stays high on return so the next word can follow at once;
    // callers that pause drop it themselves.
    task automatic send_command(logic [2:0] cmd, logic [63:0] key, logic [63:0] hash,
                                logic [63:0] data, logic [10:0] sidx);
        int gap;
        gap = 0;
        if ($urandom_range(99) < idle_pct) gap = $urandom_range(6, 1);
        if (gap != 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start <= 1'b1;
        i_cmd <= cmd;
        i_key_value <= key;
        i_hash_value <= hash;
        i_data_value <= data;
        i_start_index <= sidx;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        board.note_command(cmd, key, hash, data, sidx);
    endtask

    // wait for all words, then drain, then write the limit
    task automatic drain_and_set_limit(logic [9:0] value);
        start <= 1'b0;
        while (board.pending.size() != 0) @(posedge i_clk);
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        i_cfg_wr_en <= 1'b1;
        i_cfg_wr_data <= value;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        board.limit = 32'(value);
    endtask

    // mostly pool keys so inserts, lookups and removes hit each other
    task automatic random_command();
        int pick;
        int sel;
        logic [2:0] cmd;
        logic [63:0] key;
        logic [63:0] hash;
        logic [10:0] sidx;
        pick = $urandom_range(99);
        if (pick < 40) cmd = CMD_INSERT;
        else if (pick < 65) cmd = CMD_LOOKUP;
        else if (pick < 85) cmd = CMD_REMOVE;
        else if (pick < 95) cmd = CMD_ITERATE;
        else if (pick < 97) cmd = CMD_CLEAR;
        else cmd = 3'($urandom_range(7, 5));
        sel = $urandom_range(15);
        if ($urandom_range(9) < 7) begin
            key = key_pool[sel];
            hash = hash_pool[sel];
        end else begin
            key = {$urandom, $urandom};
            hash = ($urandom_range(1)) ? {$urandom, $urandom} : 64'($urandom_range(7));
        end
        sidx = ($urandom_range(9) == 0) ? 11'($urandom_range(2047, 1024))
                                         : 11'($urandom_range(1023));
        send_command(cmd, key, hash, {$urandom, $urandom}, sidx);
    endtask

    initial begin
        board = new();
        cycle_count = 0;
        idle_pct = 0;
        i_rst_n = 1'b0;
        start = 1'b0;
        i_cfg_wr_en = 1'b0;
        i_cfg_wr_data = '0;
        i_cmd = CMD_LOOKUP;
        i_key_value = '0;
        i_hash_value = '0;
        i_data_value = '0;
        i_start_index = '0;
        foreach (key_pool[i]) begin
            key_pool[i] = {$urandom, $urandom};
            // six pool keys share one hash to force long collision chains
            hash_pool[i] = (i < 6) ? 64'd5 : {$urandom, $urandom};
        end
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);

        // directed: extremes, duplicates, tombstones, iterate ends, bad codes
        send_command(CMD_LOOKUP, '0, '0, '0, '0);
        send_command(CMD_INSERT, '0, '0, '1, '0);
        send_command(CMD_INSERT, '1, '1, '0, '0);
        send_command(CMD_INSERT, '0, '0, 64'h1234, '0);
        send_command(CMD_INSERT, 64'h55, '0, 64'hAA, '0);
        send_command(CMD_LOOKUP, 64'h55, '0, '0, '0);
        send_command(CMD_REMOVE, '0, '0, '0, '0);
        send_command(CMD_REMOVE, '0, '0, '0, '0);
        send_command(CMD_LOOKUP, 64'h55, '0, '0, '0);
        send_command(CMD_ITERATE, '0, '0, '0, '0);
        send_command(CMD_ITERATE, '0, '0, '0, 11'd1023);
        send_command(CMD_ITERATE, '0, '0, '0, 11'd1024);
        send_command(CMD_ITERATE, '0, '0, '0, 11'h7FF);
        send_command(3'd5, '1, '1, '1, 11'h7FF);
        send_command(3'd7, '0, '0, '0, '0);
        send_command(CMD_CLEAR, '0, '0, '0, '0);
        send_command(CMD_LOOKUP, 64'h55, '0, '0, '0);

        // small limit: fill up and get refused
        drain_and_set_limit(10'd3);
        for (int i = 0; i < 5; i++) send_command(CMD_INSERT, 64'(i), 64'(i), 64'(i), '0);
        drain_and_set_limit(10'd0);
        send_command(CMD_INSERT, 64'h99, 64'h99, '0, '0);
        send_command(CMD_CLEAR, '0, '0, '0, '0);

        // random phases under various limits and idle rates
        for (int ph = 0; ph < 8; ph++) begin
            case (ph % 4)
                0: idle_pct = 0;
                1: idle_pct = 75;
                2: idle_pct = 16;
                default: idle_pct = 0;
            endcase
            case (ph)
                0: drain_and_set_limit(10'd1023);
                1: drain_and_set_limit(10'd1);
                2: drain_and_set_limit(10'd8);
                3: drain_and_set_limit(10'd682);
                default: drain_and_set_limit(10'($urandom_range(1023, 1)));
            endcase
            for (int n = 0; n < 100; n++) begin
                random_command();
                if (n == 50) begin
                    start <= 1'b0;
                    while (board.pending.size() != 0) @(posedge i_clk);
                end
            end
        end

        // heavy fill with the highest limit and hashes drawn from 0 to 3
        drain_and_set_limit(10'd1023);
        idle_pct = 0;
        for (int n = 0; n < 40; n++)
            send_command(CMD_INSERT, {$urandom, $urandom}, 64'($urandom_range(3)),
                         {$urandom, $urandom}, '0);

        start <= 1'b0;
        while (board.pending.size() != 0) @(posedge i_clk);
        repeat (1100) @(posedge i_clk);
        if (board.errors == 0 && board.pending.size() == 0) begin
            $display("open_address_hash_table_unit regression: pass");
        end else begin
            $display("open_address_hash_table_unit regression: fail");
        end
        $finish;
    end
endmodule
